// ===== rtl/core/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg: shared constants and types for the sum-16 sensor frame parser
// Frame layout constants, status codes, parser states and the read-out
// address map of the frame store.
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

  localparam int unsigned FrameBytesDef = 32;
  localparam int unsigned StoreDepth    = 30;
  localparam int unsigned AddrW         = $clog2(StoreDepth);
  localparam int unsigned PosW          = 6;
  localparam int unsigned FieldW        = 4;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned ValueW        = 16;
  localparam int unsigned StatusW       = 3;

  // frame layout
  localparam int unsigned HdrFirstPos   = 0;
  localparam int unsigned HdrSecondPos  = 1;
  localparam int unsigned LenHighPos    = 2;
  localparam int unsigned LenLowPos     = 3;
  localparam int unsigned WordBasePos   = 4;
  localparam int unsigned VersionPos    = 28;
  localparam int unsigned ErrorPos      = 29;

  localparam logic [ByteW-1:0] HeaderFirst    = 8'h42;
  localparam logic [ByteW-1:0] HeaderSecond   = 8'h4D;
  localparam logic [ByteW-1:0] LengthExpected = 8'd28;

  // result fields
  localparam logic [FieldW-1:0] WordCount  = 4'd12;
  localparam logic [FieldW-1:0] VersionIdx = 4'd12;
  localparam logic [FieldW-1:0] ErrorIdx   = 4'd13;

  typedef enum logic [StatusW-1:0] {
    StOk     = 3'd0,
    StSum    = 3'd1,
    StHeader = 3'd2,
    StLength = 3'd3,
    StSensor = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SCollect,
    SRdHi,
    SRdLo,
    SLoad
  } state_e;

  // Store address of the high (lo_sel = 0) or low (lo_sel = 1) byte of a
  // result field. Version and error byte are single bytes: both map to one.
  function automatic logic [AddrW-1:0] field_addr(input logic [FieldW-1:0] idx,
                                                  input logic              lo_sel);
    logic [PosW-1:0] a;
    if (idx < WordCount) begin
      a = PosW'(WordBasePos) + {1'b0, idx, 1'b0} + {{(PosW-1){1'b0}}, lo_sel};
    end else begin
      a = PosW'(VersionPos) + {{(PosW-FieldW){1'b0}}, idx - VersionIdx};
    end
    return a[AddrW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfp_ram.sv =====
// ----------------------------------------------------------------------------
// sfp_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 30,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/sensor_frame_parser_sum16.sv =====
// ----------------------------------------------------------------------------
// sensor_frame_parser_sum16: sum-16 checked sensor frame parser
// Collects FRAME_BYTES received bytes, checks sum, header and length, and
// decodes the twelve measurement words, version and error byte.
// ----------------------------------------------------------------------------
// One byte word is taken per cycle while a frame is being collected. Bytes
// 0..29 are written into a 30-entry frame store (registered-read RAM); the
// bytes ahead of the checksum word feed a 16-bit wrapping sum. On the last
// byte the sum, the header 0x42 0x4D and the length word 28 are checked in
// that order. A failed check yields one error result with last set, and the
// parser is ready for the next frame on the following cycle. A good frame
// yields a 14-result burst read out of the frame store: the store has one
// read port and each measurement needs two byte reads, so after an SRdHi
// setup state each result takes SRdLo and SLoad; output stalls stretch it.
// No byte is accepted during the burst. The last byte of a frame also waits
// while an earlier result is still held in the output register. Asserting
// restart with a byte drops the partial frame and makes that byte byte 0.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_parser_sum16
  import sfp_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // byte input
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ByteW-1:0]   rx_byte_i,
  input  wire logic               restart_i,
  // result output
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [FieldW-1:0]  field_index_o,
  output logic      [ValueW-1:0]  field_value_o,
  output logic      [StatusW-1:0] status_o,
  output logic                    last_o
);

  localparam logic [PosW-1:0] LastPos  = PosW'(FRAME_BYTES - 1);
  localparam logic [PosW-1:0] ChkPos   = PosW'(FRAME_BYTES - 2);
  localparam logic [PosW-1:0] StoreEnd = PosW'(StoreDepth);

  // collection state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [ValueW-1:0] sum_q, sum_d;
  logic [ByteW-1:0]  chk_hi_q, chk_hi_d;

  // per-position check flags, refreshed whenever that store entry is written
  logic hdr0_ok_q, hdr1_ok_q, len_hi_ok_q, len_lo_ok_q, sens_nz_q;

  // read-out state
  state_e            state_q, state_d;
  logic [FieldW-1:0] fld_q, fld_d;
  logic [ByteW-1:0]  hi_q, hi_d;
  status_e           burst_st_q, burst_st_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic [FieldW-1:0]  out_idx_q, out_idx_d;
  logic [ValueW-1:0]  out_val_q, out_val_d;
  status_e            out_st_q, out_st_d;
  logic               out_last_q, out_last_d;

  // store ports
  logic             st_we;
  logic [AddrW-1:0] st_raddr;
  logic [ByteW-1:0] st_rdata;

  // datapath
  logic [PosW-1:0]   pos_eff;
  logic [ValueW-1:0] sum_base;
  logic [ValueW-1:0] chk_word;
  logic              fire_in;
  logic              is_last_pos;
  logic              in_sum;
  logic              out_free;
  status_e           frame_st;

  sfp_ram #(
    .Width (ByteW),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (pos_eff[AddrW-1:0]),
    .wdata_i (rx_byte_i),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // A restart byte counts as byte 0 of a fresh frame.
  assign pos_eff  = restart_i ? '0 : pos_q;
  assign sum_base = restart_i ? '0 : sum_q;

  assign out_free    = !out_valid_q || out_ready_i;
  // last byte must find the output register free (an error result goes there)
  assign in_ready_o  = (state_q == SCollect) && ((pos_q != LastPos) || out_free);
  assign fire_in     = in_valid_i && in_ready_o;
  assign is_last_pos = (pos_eff == LastPos);
  assign in_sum      = (pos_eff < ChkPos);
  assign st_we       = fire_in && in_sum && (pos_eff < StoreEnd);
  assign chk_word    = {chk_hi_q, rx_byte_i};

  // frame checks, first failure wins
  always_comb begin
    if (sum_base != chk_word) begin
      frame_st = StSum;
    end else if (!(hdr0_ok_q && hdr1_ok_q)) begin
      frame_st = StHeader;
    end else if (!(len_hi_ok_q && len_lo_ok_q)) begin
      frame_st = StLength;
    end else begin
      frame_st = StOk;
    end
  end

  // byte position, running sum and checksum high byte
  always_comb begin
    pos_d    = pos_q;
    sum_d    = sum_q;
    chk_hi_d = chk_hi_q;
    if (fire_in) begin
      if (is_last_pos) begin
        pos_d = '0;
        sum_d = '0;
      end else begin
        pos_d = pos_eff + 1'b1;
        sum_d = in_sum ? sum_base + {{(ValueW-ByteW){1'b0}}, rx_byte_i} : sum_base;
      end
      if (pos_eff == ChkPos) begin
        chk_hi_d = rx_byte_i;
      end
    end
  end

  // read-out sequencer and output register loading
  always_comb begin
    state_d    = state_q;
    fld_d      = fld_q;
    hi_d       = hi_q;
    burst_st_d = burst_st_q;
    st_raddr   = field_addr(fld_q, 1'b1);

    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_st_d    = out_st_q;
    out_last_d  = out_last_q;

    case (state_q)
      SCollect: begin
        if (fire_in && is_last_pos) begin
          if (frame_st != StOk) begin
            out_valid_d = 1'b1;
            out_idx_d   = '0;
            out_val_d   = '0;
            out_st_d    = frame_st;
            out_last_d  = 1'b1;
          end else begin
            state_d    = SRdHi;
            fld_d      = '0;
            burst_st_d = sens_nz_q ? StSensor : StOk;
          end
        end
      end
      SRdHi: begin
        st_raddr = field_addr(fld_q, 1'b0);
        state_d  = SRdLo;
      end
      SRdLo: begin
        hi_d    = st_rdata;
        state_d = SLoad;
      end
      SLoad: begin
        // address holds on the low byte while the output stalls
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = fld_q;
          out_val_d   = (fld_q < WordCount) ? {hi_q, st_rdata}
                                            : {{(ValueW-ByteW){1'b0}}, st_rdata};
          out_st_d    = burst_st_q;
          out_last_d  = (fld_q == ErrorIdx);
          if (fld_q == ErrorIdx) begin
            state_d = SCollect;
          end else begin
            fld_d    = fld_q + 1'b1;
            st_raddr = field_addr(fld_q + 1'b1, 1'b0);
            state_d  = SRdLo;
          end
        end
      end
      default: begin
        state_d = SCollect;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SCollect;
      pos_q       <= '0;
      sum_q       <= '0;
      chk_hi_q    <= '0;
      fld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      chk_hi_q    <= chk_hi_d;
      fld_q       <= fld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    hi_q       <= hi_d;
    burst_st_q <= burst_st_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_st_q   <= out_st_d;
    out_last_q <= out_last_d;
    if (st_we) begin
      if (pos_eff == PosW'(HdrFirstPos))  hdr0_ok_q   <= (rx_byte_i == HeaderFirst);
      if (pos_eff == PosW'(HdrSecondPos)) hdr1_ok_q   <= (rx_byte_i == HeaderSecond);
      if (pos_eff == PosW'(LenHighPos))   len_hi_ok_q <= (rx_byte_i == '0);
      if (pos_eff == PosW'(LenLowPos))    len_lo_ok_q <= (rx_byte_i == LengthExpected);
      if (pos_eff == PosW'(ErrorPos))     sens_nz_q   <= (rx_byte_i != '0);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign field_index_o = out_idx_q;
  assign field_value_o = out_val_q;
  assign status_o      = out_st_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/sfp_checker.sv =====
// ----------------------------------------------------------------------------
// sfp_checker: port-level checks for the sensor frame parser
// Watches the result channel of the top level; bound to it below.
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_checker
  import sfp_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic [FieldW-1:0]  field_index_o,
  input wire logic [ValueW-1:0]  field_value_o,
  input wire logic [StatusW-1:0] status_o,
  input wire logic               last_o
);

  logic frame_err;
  assign frame_err = (status_o == StSum) || (status_o == StHeader) ||
                     (status_o == StLength);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(field_value_o) &&
                                   $stable(field_index_o) && $stable(last_o))
    else $error("result word changed while stalled");

  // frame error results are a single zeroed word
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_err |-> last_o && field_index_o == '0 &&
                                 field_value_o == '0)
    else $error("malformed frame error result");

  // burst words end exactly at the error byte field
  a_burst_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_err |-> (last_o == (field_index_o == ErrorIdx)))
    else $error("burst last flag misplaced");

  // version and error byte are zero-extended bytes
  a_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_err && field_index_o >= VersionIdx |->
      field_value_o[ValueW-1:ByteW] == '0 && field_index_o <= ErrorIdx)
    else $error("byte field out of range");

endmodule

bind sensor_frame_parser_sum16 sfp_checker u_sfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .field_index_o (field_index_o),
  .field_value_o (field_value_o),
  .status_o      (status_o),
  .last_o        (last_o)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for sensor_frame_parser_sum16
// Drives 32-byte sensor frames, good and broken, and checks every result word
// against a cycle-free frame decoder kept alongside the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import sfp_pkg::*;

  localparam int unsigned FrameLen    = FrameBytesDef;
  localparam int unsigned ItemTarget  = 460;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldCycles  = 300;

  // frame corruption flags, may be or-ed together
  localparam int FaultNone = 0;
  localparam int FaultSum  = 1;
  localparam int FaultHdr  = 2;
  localparam int FaultLen  = 4;

  typedef struct {
    logic [FieldW-1:0] idx;
    logic [ValueW-1:0] value;
    status_e           status;
    logic              last;
  } field_rec_t;

  // DUT ports; every input known from time zero
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [ByteW-1:0]   rx_byte_i   = '0;
  logic               restart_i   = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [FieldW-1:0]  field_index_o;
  logic [ValueW-1:0]  field_value_o;
  logic [StatusW-1:0] status_o;
  logic               last_o;

  sensor_frame_parser_sum16 #(
    .FRAME_BYTES(FrameLen)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .field_index_o(field_index_o),
    .field_value_o(field_value_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  // Decoder state: position in frame, running sum, stored bytes 0..29 and
  // the checksum high byte.
  logic [PosW-1:0]  frame_pos;
  logic [15:0]      frame_sum;
  logic [ByteW-1:0] byte_store [StoreDepth];
  logic [ByteW-1:0] check_hi;

  field_rec_t       pending_fields [$];   // result words still owed by the DUT
  logic [ByteW-1:0] frame_buf [FrameLen]; // frame being sent
  int               fail_cnt   = 0;
  int               bytes_sent = 0;
  int               cycle_cnt  = 0;
  int               hold_left  = 0;       // long receiver hold-off, cycles
  bit               idle_en    = 1'b1;    // random gaps/stalls on both sides

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Frame decoder
  // ---------------------------------------------------------------------------
  function automatic void expect_field(input logic [FieldW-1:0] idx,
                                       input logic [ValueW-1:0] value,
                                       input status_e           st,
                                       input logic              last);
    field_rec_t rec;
    rec.idx    = idx;
    rec.value  = value;
    rec.status = st;
    rec.last   = last;
    pending_fields.push_back(rec);
  endfunction

  // Consume one accepted input word and queue the result words it causes.
  function automatic void parse_byte(input logic [ByteW-1:0] b, input logic rs);
    logic [15:0] chk;
    status_e     st;
    if (rs) begin
      frame_pos = '0;
      frame_sum = '0;
    end
    if (frame_pos >= FrameLen) begin
      frame_pos = '0;
      frame_sum = '0;
    end
    if (frame_pos < FrameLen - 2) begin
      frame_sum = frame_sum + 16'(b);
      if (frame_pos < StoreDepth) byte_store[frame_pos] = b;
      frame_pos = frame_pos + 1'b1;
    end else if (frame_pos == FrameLen - 2) begin
      check_hi  = b;
      frame_pos = frame_pos + 1'b1;
    end else begin
      // final byte: sum first, then header, then length; first failure wins
      chk = {check_hi, b};
      if (frame_sum != chk) begin
        st = StSum;
      end else if (byte_store[HdrFirstPos] != HeaderFirst ||
                   byte_store[HdrSecondPos] != HeaderSecond) begin
        st = StHeader;
      end else if ({byte_store[LenHighPos], byte_store[LenLowPos]} !=
                   {8'h00, LengthExpected}) begin
        st = StLength;
      end else begin
        st = StOk;
      end
      frame_pos = '0;
      frame_sum = '0;
      if (st != StOk) begin
        expect_field('0, '0, st, 1'b1);
      end else begin
        // nonzero sensor error byte flags the whole burst
        if (byte_store[ErrorPos] != '0) st = StSensor;
        for (int i = 0; i < WordCount; i++) begin
          expect_field(FieldW'(i), {byte_store[WordBasePos + 2 * i],
                                    byte_store[WordBasePos + 2 * i + 1]}, st, 1'b0);
        end
        expect_field(VersionIdx, {8'h00, byte_store[VersionPos]}, st, 1'b0);
        expect_field(ErrorIdx, {8'h00, byte_store[ErrorPos]}, st, 1'b1);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Failure bookkeeping: first ten printed, the rest only counted
  // ---------------------------------------------------------------------------
  function automatic void note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("%s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one word per call, optional idle burst ahead of it.
  // Drives at the falling edge, sees acceptance at the rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [ByteW-1:0] b, input logic rs);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    restart_i  <= rs;
    do @(posedge clk_i); while (!in_ready_o);
    parse_byte(b, rs);
    bytes_sent++;
  endtask

  // Random body with a valid header, length word and the given error byte.
  function automatic void fill_frame(input logic [ByteW-1:0] err_byte);
    for (int i = 0; i < FrameLen; i++) frame_buf[i] = 8'($urandom);
    frame_buf[HdrFirstPos]  = HeaderFirst;
    frame_buf[HdrSecondPos] = HeaderSecond;
    frame_buf[LenHighPos]   = 8'h00;
    frame_buf[LenLowPos]    = LengthExpected;
    frame_buf[ErrorPos]     = err_byte;
  endfunction

  // Apply requested corruption and write the checksum word.
  function automatic void finish_frame(input int faults);
    logic [15:0] s;
    if (faults & FaultHdr)
      frame_buf[$urandom_range(HdrFirstPos, HdrSecondPos)] ^= 8'($urandom_range(1, 255));
    if (faults & FaultLen)
      frame_buf[$urandom_range(LenHighPos, LenLowPos)] ^= 8'($urandom_range(1, 255));
    s = '0;
    for (int i = 0; i < FrameLen - 2; i++) s = s + 16'(frame_buf[i]);
    if (faults & FaultSum) s = s ^ 16'($urandom_range(1, 16'hFFFF));
    frame_buf[FrameLen - 2] = s[15:8];
    frame_buf[FrameLen - 1] = s[7:0];
  endfunction

  // First n bytes of frame_buf; restart on byte 0 realigns the parser.
  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) send_byte(frame_buf[i], i == 0);
  endtask

  // Input word withdrawn first, then wait for every owed result.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stalls, plus the long hold-off when requested
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 9);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    field_rec_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_fields.size() == 0) begin
        note_fail($sformatf("unexpected result: idx %0d value %h status %0d last %b",
                            field_index_o, field_value_o, status_o, last_o));
      end else begin
        want = pending_fields.pop_front();
        if (field_index_o != want.idx || field_value_o != want.value ||
            status_o != want.status || last_o != want.last) begin
          note_fail($sformatf({"result mismatch: exp idx %0d value %h status %0d last %b,",
                               " got idx %0d value %h status %0d last %b"},
                              want.idx, want.value, want.status, want.last,
                              field_index_o, field_value_o, status_o, last_o));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("sensor_frame_parser_sum16 test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Good frame with field extremes: words alternate all-ones and zero,
  // version byte all ones.
  task automatic test_good_frame();
    fill_frame(8'h00);
    for (int i = 0; i < WordCount; i++) begin
      frame_buf[WordBasePos + 2 * i]     = (i % 2 == 0) ? 8'hFF : 8'h00;
      frame_buf[WordBasePos + 2 * i + 1] = (i % 2 == 0) ? 8'hFF : 8'h00;
    end
    frame_buf[VersionPos] = 8'hFF;
    finish_frame(FaultNone);
    send_frame(FrameLen);
  endtask

  // Nonzero sensor error byte: full burst, every word flagged.
  task automatic test_sensor_error();
    fill_frame(8'hFF);
    frame_buf[VersionPos] = 8'h00;
    finish_frame(FaultNone);
    send_frame(FrameLen);
  endtask

  // Several failures at once: only the first check in order is reported.
  task automatic test_check_order();
    fill_frame(8'h00);
    finish_frame(FaultSum | FaultHdr | FaultLen);
    send_frame(FrameLen);
    fill_frame(8'h01);
    finish_frame(FaultHdr | FaultLen);
    send_frame(FrameLen);
    fill_frame(8'h00);
    finish_frame(FaultLen);
    send_frame(FrameLen);
  endtask

  // A partial frame dropped by restart, cut just before the
  // final byte (restart lands on the checksum low position).
  task automatic test_restart();
    fill_frame(8'h00);
    finish_frame(FaultNone);
    send_frame(FrameLen - 1);
    fill_frame(8'h00);
    finish_frame(FaultNone);
    send_frame(FrameLen);
  endtask

  // Receiver holds off long enough for the burst to back up into the input.
  task automatic test_output_backpressure();
    idle_en   = 1'b0;
    hold_left = HoldCycles;
    repeat (2) begin
      fill_frame(8'h00);
      finish_frame(FaultNone);
      send_frame(FrameLen);
    end
    idle_en = 1'b1;
  endtask

  // Sender pauses until every owed result word has come back.
  task automatic test_pause_until_drained();
    fill_frame(8'h00);
    finish_frame(FaultNone);
    send_frame(FrameLen);
    wait_drained();
    fill_frame(8'h00);
    finish_frame(FaultSum);
    send_frame(FrameLen);
    wait_drained();
  endtask

  // Mostly well-formed frames with random content, mixed with broken frames,
  // truncated frames and loose noise with random restarts.
  task automatic test_random_traffic();
    int kind;
    int n;
    while (bytes_sent < ItemTarget - 2 * FrameLen) begin
      idle_en = ($urandom_range(0, 3) != 0);
      kind    = $urandom_range(0, 9);
      if (kind <= 5) begin
        fill_frame((kind == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
        finish_frame(FaultNone);
        send_frame(FrameLen);
      end else if (kind <= 7) begin
        fill_frame(8'($urandom));
        finish_frame($urandom_range(FaultSum, FaultSum | FaultHdr | FaultLen));
        send_frame(FrameLen);
      end else if (kind == 8) begin
        fill_frame(8'h00);
        finish_frame(FaultNone);
        send_frame($urandom_range(1, FrameLen - 1));
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_no_idle_tail();
    idle_en = 1'b0;
    repeat (2) begin
      fill_frame(8'h00);
      finish_frame(FaultNone);
      send_frame(FrameLen);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    frame_pos = '0;
    frame_sum = '0;
    check_hi  = '0;
    for (int i = 0; i < StoreDepth; i++) byte_store[i] = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_good_frame();
    test_sensor_error();
    test_check_order();
    test_restart();
    test_output_backpressure();
    test_pause_until_drained();
    test_random_traffic();
    test_no_idle_tail();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_cnt == 0 && pending_fields.size() == 0) begin
      $display("sensor_frame_parser_sum16 test passed");
    end else begin
      $display("sensor_frame_parser_sum16 test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
